@@ rtl/eur_pkg.sv @@
// shared types and constants for the euler angle to rotation matrix block
// no dependencies
`default_nettype none
package eur_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int WORK_FRAC    = 30;
  // sincos unit depth: input fold, one stage per cordic step, quadrant unfold
  localparam int SC_LATENCY   = CORDIC_STEPS + 2;

  typedef logic signed [35:0] cval_t;   // cordic x and y, Q32
  typedef logic signed [33:0] zval_t;   // cordic residual phase
  typedef logic signed [31:0] q30_t;    // sine, cosine and products, Q30
  typedef logic signed [35:0] acc_t;    // matrix entry before output rounding

  localparam cval_t X_INIT = 36'sd2608131496;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  // arctan(2^-i) in phase units of 2^32 per turn
  function automatic logic [29:0] atan_phase(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/eur_if.sv @@
// valid/ready channel interfaces for angle transactions and matrix transactions
// depends on eur_pkg
`default_nettype none
interface eur_in_if import eur_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface eur_out_if import eur_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/eur_sincos.sv @@
// pipelined cordic sine and cosine of one binary angle, one step per stage
// depends on eur_pkg
`default_nettype none
module eur_sincos import eur_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] angle,
  output q30_t        sin_q30,
  output q30_t        cos_q30
);

  cval_t      x_r [0:CORDIC_STEPS];
  cval_t      y_r [0:CORDIC_STEPS];
  zval_t      z_r [0:CORDIC_STEPS];
  logic [1:0] q_r [0:CORDIC_STEPS];
  q30_t       sin_r, cos_r;

  logic signed [31:0] ang_ext;
  logic [31:0]        phase, qsum, resid;
  logic [1:0]         quad;

  // fold to the nearest quadrant, leaving a residual in [-1/8, 1/8) turn
  always_comb begin
    ang_ext = 32'(signed'(angle));
    phase   = 32'(ang_ext <<< (32 - ANGLE_BITS));
    qsum    = phase + 32'h2000_0000;
    quad    = qsum[31:30];
    resid   = phase - {quad, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= X_INIT;
      y_r[0] <= '0;
      z_r[0] <= 34'(signed'(resid));
      q_r[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cval_t dx, dy, x_nxt, y_nxt;
    zval_t at, z_nxt;
    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      at = zval_t'(atan_phase(i));
      if (!z_r[i][33]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - at;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + at;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        q_r[i+1] <= q_r[i];
      end
    end
  end

  cval_t xf, yf, c_raw, s_raw, c_rnd, s_rnd;
  q30_t  c_nxt, s_nxt;

  localparam cval_t ONE_Q30 = 36'sd1 <<< WORK_FRAC;

  // unfold the quadrant, round Q32 to Q30 and clamp to one
  always_comb begin
    xf = x_r[CORDIC_STEPS];
    yf = y_r[CORDIC_STEPS];
    case (q_r[CORDIC_STEPS])
      2'd1:    begin c_raw = -yf; s_raw = xf;  end
      2'd2:    begin c_raw = -xf; s_raw = -yf; end
      2'd3:    begin c_raw = yf;  s_raw = -xf; end
      default: begin c_raw = xf;  s_raw = yf;  end
    endcase
    c_rnd = (c_raw + 36'sd2) >>> 2;
    s_rnd = (s_raw + 36'sd2) >>> 2;
    if (c_rnd > ONE_Q30)       c_nxt = 32'(ONE_Q30);
    else if (c_rnd < -ONE_Q30) c_nxt = 32'(-ONE_Q30);
    else                       c_nxt = 32'(c_rnd);
    if (s_rnd > ONE_Q30)       s_nxt = 32'(ONE_Q30);
    else if (s_rnd < -ONE_Q30) s_nxt = 32'(-ONE_Q30);
    else                       s_nxt = 32'(s_rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_nxt;
      sin_r <= s_nxt;
    end
  end

  assign sin_q30 = sin_r;
  assign cos_q30 = cos_r;

endmodule
`default_nettype wire

@@ rtl/euler_to_rotation_matrix.sv @@
// euler angles (pitch x, yaw y, roll z) to the nine entries of Ry*Rx*Rz
// depends on eur_pkg, eur_if and eur_sincos
//
// usage:
//   in_chan carries one transaction of three binary angles (2^ANGLE_BITS
//   units per turn), out_chan one transaction of nine signed entries with
//   COEF_FRAC_BITS fraction bits, saturated to plus or minus one.
//   both channels are valid/ready; a transaction moves when both are high.
// pipeline and throughput:
//   stages from accepted input to out_chan.valid, in order: one fold
//   stage, 31 cordic stages, one quadrant unfold stage, two multiply stages
//   and the output register. one transaction per cycle while not stalled;
//   the depth is set by the one-step-per-stage cordic pipelines.
// stall:
//   the whole pipeline advances while the output register is empty or being
//   taken, and in_chan.ready is that same enable; nothing is lost or repeated
// reset:
//   synchronous active-low rst_n clears all valid bits; the data registers
//   are not reset
`default_nettype none
module euler_to_rotation_matrix import eur_pkg::*; #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  eur_in_if.sink   in_chan,
  eur_out_if.source out_chan
);

  localparam int   SH      = WORK_FRAC - COEF_FRAC_BITS;
  localparam acc_t RND     = (36'sd1 <<< SH) >>> 1;
  localparam acc_t ONE_OUT = 36'sd1 <<< COEF_FRAC_BITS;

  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = (p + 64'sd536870912) >>> WORK_FRAC;
    return 32'(p);
  endfunction

  function automatic logic [15:0] emit(input acc_t v);
    acc_t r;
    r = (v + RND) >>> SH;
    if (r > ONE_OUT)       r = ONE_OUT;
    else if (r < -ONE_OUT) r = -ONE_OUT;
    return r[15:0];
  endfunction

  logic en;
  logic out_v_r;
  logic vld_r [0:SC_LATENCY-1];

  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en;

  q30_t sx, cx, sy, cy, sz, cz;

  eur_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk(clk), .en(en), .angle(in_chan.data.pitch_angle), .sin_q30(sx), .cos_q30(cx));
  eur_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk(clk), .en(en), .angle(in_chan.data.yaw_angle), .sin_q30(sy), .cos_q30(cy));
  eur_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk(clk), .en(en), .angle(in_chan.data.roll_angle), .sin_q30(sz), .cos_q30(cz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SC_LATENCY; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int k = 1; k < SC_LATENCY; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // first multiply stage: pairwise products
  logic m1_v_r;
  q30_t cycz_r, sxsy_r, czsx_r, cysz_r, cxsy_r, cxsz_r, cxcz_r, czsy_r;
  q30_t cysx_r, sysz_r, cxcy_r, sx1_r, sy1_r, sz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (en) m1_v_r <= vld_r[SC_LATENCY-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cycz_r <= mulq(cy, cz);
      sxsy_r <= mulq(sx, sy);
      czsx_r <= mulq(cz, sx);
      cysz_r <= mulq(cy, sz);
      cxsy_r <= mulq(cx, sy);
      cxsz_r <= mulq(cx, sz);
      cxcz_r <= mulq(cx, cz);
      czsy_r <= mulq(cz, sy);
      cysx_r <= mulq(cy, sx);
      sysz_r <= mulq(sy, sz);
      cxcy_r <= mulq(cx, cy);
      sx1_r  <= sx;
      sy1_r  <= sy;
      sz1_r  <= sz;
    end
  end

  // second multiply stage: triple products, pairs carried along
  logic m2_v_r;
  q30_t t_sxsysz_r, t_czsxsy_r, t_cysxsz_r, t_cyczsx_r;
  q30_t cycz2_r, cysz2_r, cxsy2_r, cxsz2_r, cxcz2_r, czsy2_r, sysz2_r, cxcy2_r, sx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (en) m2_v_r <= m1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sxsysz_r <= mulq(sxsy_r, sz1_r);
      t_czsxsy_r <= mulq(czsx_r, sy1_r);
      t_cysxsz_r <= mulq(cysx_r, sz1_r);
      t_cyczsx_r <= mulq(cycz_r, sx1_r);
      cycz2_r    <= cycz_r;
      cysz2_r    <= cysz_r;
      cxsy2_r    <= cxsy_r;
      cxsz2_r    <= cxsz_r;
      cxcz2_r    <= cxcz_r;
      czsy2_r    <= czsy_r;
      sysz2_r    <= sysz_r;
      cxcy2_r    <= cxcy_r;
      sx2_r      <= sx1_r;
    end
  end

  // sums, output rounding and saturation
  out_item_t out_nxt, out_d_r;

  always_comb begin
    out_nxt.m00 = emit(acc_t'(cycz2_r) - acc_t'(t_sxsysz_r));
    out_nxt.m01 = emit(acc_t'(t_czsxsy_r) + acc_t'(cysz2_r));
    out_nxt.m02 = emit(-acc_t'(cxsy2_r));
    out_nxt.m10 = emit(-acc_t'(cxsz2_r));
    out_nxt.m11 = emit(acc_t'(cxcz2_r));
    out_nxt.m12 = emit(acc_t'(sx2_r));
    out_nxt.m20 = emit(acc_t'(czsy2_r) + acc_t'(t_cysxsz_r));
    out_nxt.m21 = emit(acc_t'(sysz2_r) - acc_t'(t_cyczsx_r));
    out_nxt.m22 = emit(acc_t'(cxcy2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= m2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) out_d_r <= out_nxt;
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_d_r;

endmodule
`default_nettype wire
